FILE: hdl/fsand_pkg.sv
package fsand_pkg;

	localparam int COORD_W = 6;
	localparam int ADDR_W  = 2 * COORD_W;
	localparam int CELL_W  = 3;

	localparam logic [2:0] CMD_STEP  = 3'd0;
	localparam logic [2:0] CMD_PLACE = 3'd1;
	localparam logic [2:0] CMD_READ  = 3'd2;
	localparam logic [2:0] CMD_UNMARK = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	localparam logic [1:0] T_NONE  = 2'd0;
	localparam logic [1:0] T_SAND  = 2'd1;
	localparam logic [1:0] T_WATER = 2'd2;
	localparam logic [1:0] T_WOOD  = 2'd3;

	// horizontal offset of probe i, before the direction is applied
	function automatic logic signed [1:0] probe_dx(input logic [2:0] i);
		case (i)
			3'd1, 3'd3: probe_dx = -2'sd1;
			3'd2, 3'd4: probe_dx = 2'sd1;
			default:    probe_dx = 2'sd0;
		endcase
	endfunction

	function automatic logic probe_dy(input logic [2:0] i);
		probe_dy = (i < 3'd3);
	endfunction

	function automatic logic may_take(input logic [1:0] mover, input logic [1:0] target);
		case (mover)
			T_SAND:  may_take = (target == T_WATER) || (target == T_NONE);
			T_WATER: may_take = (target == T_NONE);
			default: may_take = 1'b1;
		endcase
	endfunction

endpackage

FILE: hdl/falling_sand_cell_update_top.sv
// channel   direction  handshake               fields
// command   in         start & !busy           command cell_x cell_y particle_type coin_flips
// result    out        done (one cycle pulse)  final_x final_y moved cell_type_out cell_checked_out
//
// place and read read the cell, then finish; a step reads the mover cell, then for each probe
//   inside the grid reads the neighbour and writes here, and writes the neighbour on a swap;
//   probes outside the grid issue no read; all grid access goes through the single port pair of the grid ram
// clear marks and clear grid sweep all 4096 cells of the ram, read then write per cell
// after reset the same sweep clears the grid, and busy stays high until it ends
// results cannot be stalled; the next item may start in the cycle done is high
module falling_sand_cell_update_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] command,
	input  logic [5:0] cell_x,
	input  logic [5:0] cell_y,
	input  logic [1:0] particle_type,
	input  logic [4:0] coin_flips,
	output logic       done,
	output logic [5:0] final_x,
	output logic [5:0] final_y,
	output logic       moved,
	output logic [1:0] cell_type_out,
	output logic       cell_checked_out
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HERE  = 4'd1;  // mover cell data arrives
	localparam logic [3:0] S_PROBE = 4'd2;  // pick neighbour, issue read
	localparam logic [3:0] S_PCHK  = 4'd3;  // neighbour data arrives, write here
	localparam logic [3:0] S_SWAP  = 4'd4;  // write neighbour, advance
	localparam logic [3:0] S_PLACE = 4'd5;
	localparam logic [3:0] S_READ  = 4'd6;
	localparam logic [3:0] S_CLRRD = 4'd7;
	localparam logic [3:0] S_CLRWR = 4'd8;

	logic [3:0] state_q;
	logic [5:0] x_q, y_q;
	logic [1:0] ptype_q, t_q, nt_q;
	logic [4:0] coins_q;
	logic [2:0] m_q, i_q;
	logic       any_q, dir_q;
	logic       stop_q;
	logic       marks_only_q, clr_resp_q;
	logic [fsand_pkg::ADDR_W-1:0] clr_q;

	// grid ram, {mark, type} per cell, address {row, column}
	logic                          we;
	logic [fsand_pkg::ADDR_W-1:0]  waddr, raddr;
	logic [fsand_pkg::CELL_W-1:0]  wdata, rdata;
	logic [1:0] rt;
	logic       rm;

	fsand_ram #(
		.WIDTH(fsand_pkg::CELL_W),
		.DEPTH(1 << fsand_pkg::ADDR_W)
	) u_grid (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rt = rdata[1:0];
	assign rm = rdata[2];

	// neighbour of the current probe, mirrored by the direction
	logic signed [1:0] dx_raw, dx;
	logic [7:0] nx_w, ny_w;
	logic       nb_in, last_probe, take_ok;
	logic [2:0] moves_w, m_next;

	always_comb begin
		dx_raw = fsand_pkg::probe_dx(i_q);
		dx = dir_q ? -dx_raw : dx_raw;
		nx_w = {2'b00, x_q} + {{6{dx[1]}}, dx};
		ny_w = {2'b00, y_q} + {7'b0, fsand_pkg::probe_dy(i_q)};
		nb_in = (nx_w[7:6] == 2'b00) && (ny_w[7:6] == 2'b00);
		last_probe = (i_q == ((t_q == fsand_pkg::T_WATER) ? 3'd4 : 3'd2));
		moves_w = (t_q == fsand_pkg::T_WATER) ? 3'd5 : 3'd3;
		m_next = m_q + 3'd1;
		take_ok = !rm && fsand_pkg::may_take(t_q, rt);
	end

	always_comb begin
		case (state_q)
			S_IDLE:  raddr = {cell_y, cell_x};
			S_PROBE: raddr = {ny_w[5:0], nx_w[5:0]};
			S_CLRRD: raddr = clr_q;
			default: raddr = {y_q, x_q};
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = {y_q, x_q};
		wdata = '0;
		case (state_q)
			S_PCHK: begin
				we = take_ok;
				wdata = {(rt != fsand_pkg::T_NONE), rt};
			end
			S_SWAP: begin
				we = 1'b1;
				waddr = {ny_w[5:0], nx_w[5:0]};
				wdata = {(nt_q != fsand_pkg::T_NONE), t_q};
			end
			S_PLACE: begin
				we = (ptype_q == fsand_pkg::T_NONE) || fsand_pkg::may_take(ptype_q, rt);
				wdata = {rm, ptype_q};
			end
			S_CLRWR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = marks_only_q ? {1'b0, rt} : 3'b000;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLRRD;  // sweep the grid clear after reset
			clr_q <= '0;
			marks_only_q <= 1'b0;
			clr_resp_q <= 1'b0;
			dir_q <= 1'b0;
			done <= 1'b0;
			any_q <= 1'b0;
			stop_q <= 1'b0;
			m_q <= '0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q <= cell_x;
						y_q <= cell_y;
						ptype_q <= particle_type;
						coins_q <= coin_flips;
						any_q <= 1'b0;
						clr_q <= '0;
						clr_resp_q <= 1'b1;
						case (command)
							fsand_pkg::CMD_STEP:  state_q <= S_HERE;
							fsand_pkg::CMD_PLACE: state_q <= S_PLACE;
							fsand_pkg::CMD_READ:  state_q <= S_READ;
							fsand_pkg::CMD_UNMARK: begin
								marks_only_q <= 1'b1;
								state_q <= S_CLRRD;
							end
							fsand_pkg::CMD_CLEAR: begin
								marks_only_q <= 1'b0;
								state_q <= S_CLRRD;
							end
							default: begin
								// unknown command, all-zero result
								done <= 1'b1;
								final_x <= '0;
								final_y <= '0;
								moved <= 1'b0;
								cell_type_out <= '0;
								cell_checked_out <= 1'b0;
							end
						endcase
					end
				end
				S_HERE: begin
					if ((rt == fsand_pkg::T_SAND || rt == fsand_pkg::T_WATER) && !rm) begin
						t_q <= rt;
						m_q <= '0;
						i_q <= '0;
						stop_q <= 1'b0;
						dir_q <= dir_q ^ coins_q[0];
						state_q <= S_PROBE;
					end else begin
						done <= 1'b1;
						final_x <= x_q;
						final_y <= y_q;
						moved <= 1'b0;
						cell_type_out <= '0;
						cell_checked_out <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_PROBE: begin
					if (nb_in) begin
						state_q <= S_PCHK;
					end else if (last_probe) begin
						done <= 1'b1;
						final_x <= x_q;
						final_y <= y_q;
						moved <= any_q;
						cell_type_out <= '0;
						cell_checked_out <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				S_PCHK: begin
					if (take_ok) begin
						nt_q <= rt;
						state_q <= S_SWAP;
					end else if (last_probe) begin
						done <= 1'b1;
						final_x <= x_q;
						final_y <= y_q;
						moved <= any_q;
						cell_type_out <= '0;
						cell_checked_out <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						// blocked inside the grid, later probes still tried, step ends after this move
						stop_q <= 1'b1;
						i_q <= i_q + 3'd1;
						state_q <= S_PROBE;
					end
				end
				S_SWAP: begin
					x_q <= nx_w[5:0];
					y_q <= ny_w[5:0];
					any_q <= 1'b1;
					// swap with a particle, an earlier block, or out of moves ends the step
					if (nt_q != fsand_pkg::T_NONE || stop_q || m_next == moves_w) begin
						done <= 1'b1;
						final_x <= nx_w[5:0];
						final_y <= ny_w[5:0];
						moved <= 1'b1;
						cell_type_out <= '0;
						cell_checked_out <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						m_q <= m_next;
						i_q <= '0;
						stop_q <= 1'b0;
						dir_q <= dir_q ^ coins_q[m_next];
						state_q <= S_PROBE;
					end
				end
				S_PLACE: begin
					done <= 1'b1;
					final_x <= '0;
					final_y <= '0;
					moved <= 1'b0;
					cell_type_out <= '0;
					cell_checked_out <= 1'b0;
					state_q <= S_IDLE;
				end
				S_READ: begin
					done <= 1'b1;
					final_x <= '0;
					final_y <= '0;
					moved <= 1'b0;
					cell_type_out <= rt;
					cell_checked_out <= rm;
					state_q <= S_IDLE;
				end
				S_CLRRD: state_q <= S_CLRWR;
				S_CLRWR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						done <= clr_resp_q;
						final_x <= '0;
						final_y <= '0;
						moved <= 1'b0;
						cell_type_out <= '0;
						cell_checked_out <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CLRRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// results only leave once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// the grid is only written while an item is at work
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> busy) else $error("grid write while idle");

	// a clear command always starts a sweep
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == fsand_pkg::CMD_CLEAR ||
		command == fsand_pkg::CMD_UNMARK)) |=> (busy && state_q == S_CLRRD))
		else $error("clear did not start sweep");

	// a swap write always follows an accepted neighbour probe
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP) |-> ($past(state_q) == S_PCHK))
		else $error("swap without probe");

endmodule

FILE: hdl/fsand_ram.sv
module fsand_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
